>>> rtl/lppd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lppd_pkg;

  localparam int BUFFER_BYTES_DEFAULT = 64;
  localparam int HEADER_BYTES = 3;
  localparam int QUEUE_DEPTH = 4;

  localparam int MAX_LEN_W = 7;
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 7'd64;
  localparam int INDEX_W = 6;
  localparam int APB_ADDR_W = 3;
  localparam logic APB_INDEX_MAX_LEN = 1'b0;

  localparam logic [1:0] CMD_STORE = 2'd0;
  localparam logic [1:0] CMD_EMIT = 2'd1;
  localparam logic [1:0] CMD_ERROR = 2'd2;

  localparam logic ACTION_DATA = 1'b0;
  localparam logic ACTION_RESTART = 1'b1;

  localparam logic STATUS_BYTE = 1'b0;
  localparam logic STATUS_ERROR = 1'b1;

endpackage

`default_nettype wire

>>> rtl/lppd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lppd_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink (input valid, input action, input data_byte, output ready);
endinterface

interface lppd_out_if;
  logic                        valid;
  logic                        ready;
  logic                        status;
  logic [7:0]                  out_byte;
  logic [lppd_pkg::INDEX_W-1:0] byte_index;
  logic [7:0]                  frame_id;
  logic                        last;

  modport source (
    output valid, output status, output out_byte, output byte_index,
    output frame_id, output last, input ready
  );
  modport sink (
    input valid, input status, input out_byte, input byte_index,
    input frame_id, input last, output ready
  );
endinterface

`default_nettype wire

>>> rtl/lppd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module lppd_front #(
  parameter int BUFFER_BYTES = lppd_pkg::BUFFER_BYTES_DEFAULT,
  localparam int AW = $clog2(BUFFER_BYTES),
  localparam int FW = $clog2(BUFFER_BYTES + 1),
  localparam int CMD_W = 2 + AW + 8 + FW + 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  lppd_in_if.sink                             in_ch,
  input  wire logic [lppd_pkg::MAX_LEN_W-1:0] max_len,
  input  wire logic                           q_full,
  output logic                                push,
  output logic [CMD_W-1:0]                    push_cmd
);

  typedef struct packed {
    logic [1:0]    kind;
    logic [AW-1:0] addr;
    logic [7:0]    data;
    logic [FW-1:0] len;
    logic [7:0]    id;
  } cmd_t;

  logic [FW-1:0] fill;
  logic          closed;
  logic [15:0]   len_reg;
  logic [7:0]    id_reg;

  logic          accept;
  logic [FW-1:0] fill_inc;
  logic          hdr_done;
  logic          len_ok;
  logic          pkt_done;
  logic [7:0]    id_cur;
  cmd_t          cmd;

  always_comb begin
    in_ch.ready = !q_full;
    accept = in_ch.valid && in_ch.ready;
    fill_inc = fill + FW'(1);
    hdr_done = fill_inc >= FW'(lppd_pkg::HEADER_BYTES);
    len_ok = (len_reg >= 16'(lppd_pkg::HEADER_BYTES)) && (len_reg <= 16'(max_len)) &&
             (len_reg <= 16'(BUFFER_BYTES));
    pkt_done = 16'(fill_inc) == len_reg;
    id_cur = (fill == FW'(2)) ? in_ch.data_byte : id_reg;
    push = accept && (in_ch.action == lppd_pkg::ACTION_DATA) && !closed;
    cmd.addr = fill[AW-1:0];
    cmd.data = in_ch.data_byte;
    cmd.len = len_reg[FW-1:0];
    cmd.id = id_cur;
    if (hdr_done && !len_ok) begin
      cmd.kind = lppd_pkg::CMD_ERROR;
    end else if (hdr_done && pkt_done) begin
      cmd.kind = lppd_pkg::CMD_EMIT;
    end else begin
      cmd.kind = lppd_pkg::CMD_STORE;
    end
    push_cmd = cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      closed <= 1'b0;
    end else if (accept) begin
      if (in_ch.action == lppd_pkg::ACTION_RESTART) begin
        fill <= '0;
        closed <= 1'b0;
      end else if (!closed) begin
        if (hdr_done && !len_ok) begin
          fill <= '0;
          closed <= 1'b1;
        end else if (hdr_done && pkt_done) begin
          fill <= '0;
        end else begin
          fill <= fill_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (fill == FW'(0)) begin
        len_reg[7:0] <= in_ch.data_byte;
      end
      if (fill == FW'(1)) begin
        len_reg[15:8] <= in_ch.data_byte;
      end
      if (fill == FW'(2)) begin
        id_reg <= in_ch.data_byte;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/lppd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module lppd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = lppd_pkg::QUEUE_DEPTH,
  localparam int PW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  pop_valid,
  output logic [WIDTH-1:0]      pop_data
);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  always_comb begin
    full = count == CW'(DEPTH);
    pop_valid = count != '0;
    pop_data = entries[rd_ptr];
    do_push = push && !full;
    do_pop = pop && pop_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> rtl/lppd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module lppd_back #(
  parameter int BUFFER_BYTES = lppd_pkg::BUFFER_BYTES_DEFAULT,
  localparam int AW = $clog2(BUFFER_BYTES),
  localparam int FW = $clog2(BUFFER_BYTES + 1),
  localparam int CMD_W = 2 + AW + 8 + FW + 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cmd_valid,
  input  wire logic [CMD_W-1:0] cmd_data,
  output logic                  cmd_pop,
  lppd_out_if.source            out_ch
);

  typedef struct packed {
    logic [1:0]    kind;
    logic [AW-1:0] addr;
    logic [7:0]    data;
    logic [FW-1:0] len;
    logic [7:0]    id;
  } cmd_t;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DRAIN = 1'b1;

  logic [7:0]    store [BUFFER_BYTES];
  logic [7:0]    rdata;

  logic          state;
  logic [AW-1:0] idx;
  logic [FW-1:0] len;
  logic [7:0]    id;
  logic          rd_pend;
  logic [AW-1:0] pend_idx;
  logic          pend_last;

  logic          out_valid;
  logic          out_status;
  logic [7:0]    out_byte;
  logic [lppd_pkg::INDEX_W-1:0] out_index;
  logic [7:0]    out_id;
  logic          out_last;

  cmd_t          cmd;
  logic          out_free;
  logic          wr_en;
  logic          rd_en;
  logic          load_err;
  logic          start;
  logic          idx_last;

  always_comb begin
    cmd = cmd_t'(cmd_data);
    out_free = !out_valid || out_ch.ready;
    idx_last = (FW'(idx) + FW'(1)) == len;
    cmd_pop = 1'b0;
    wr_en = 1'b0;
    rd_en = 1'b0;
    load_err = 1'b0;
    start = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid && !rd_pend) begin
          unique case (cmd.kind)
            lppd_pkg::CMD_STORE: begin
              wr_en = 1'b1;
              cmd_pop = 1'b1;
            end
            lppd_pkg::CMD_EMIT: begin
              wr_en = 1'b1;
              cmd_pop = 1'b1;
              start = 1'b1;
            end
            lppd_pkg::CMD_ERROR: begin
              if (out_free) begin
                load_err = 1'b1;
                cmd_pop = 1'b1;
              end
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      S_DRAIN: begin
        rd_en = out_free && !rd_pend;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[cmd.addr] <= cmd.data;
    end
    if (rd_en) begin
      rdata <= store[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= rd_en;
      if (start) begin
        state <= S_DRAIN;
      end else if (rd_en && idx_last) begin
        state <= S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      idx <= '0;
      len <= cmd.len;
      id <= cmd.id;
    end else if (rd_en) begin
      idx <= idx + AW'(1);
      pend_idx <= idx;
      pend_last <= idx_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_pend || load_err) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend) begin
      out_status <= lppd_pkg::STATUS_BYTE;
      out_byte <= rdata;
      out_index <= lppd_pkg::INDEX_W'(pend_idx);
      out_id <= id;
      out_last <= pend_last;
    end else if (load_err) begin
      out_status <= lppd_pkg::STATUS_ERROR;
      out_byte <= '0;
      out_index <= '0;
      out_id <= '0;
      out_last <= 1'b1;
    end
  end

  always_comb begin
    out_ch.valid = out_valid;
    out_ch.status = out_status;
    out_ch.out_byte = out_byte;
    out_ch.byte_index = out_index;
    out_ch.frame_id = out_id;
    out_ch.last = out_last;
  end

endmodule

`default_nettype wire

>>> rtl/length_prefixed_packet_deframer.sv
// A byte is taken in the cycle it is offered whenever the four-entry command queue has room.
// The back end stores one byte per cycle while it is not draining a packet. It drains a packet
// one byte at a time; each registered read of the packet store waits for the previous read and
// for room in the output register. A packet's bytes reach the output through the command queue,
// the store read and the output register. Reset is synchronous and clears the stream state, the
// queue and the output valid flag and loads max_packet_len with 64; the packet store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_packet_deframer #(
  parameter int BUFFER_BYTES = lppd_pkg::BUFFER_BYTES_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  lppd_in_if.sink                              in_ch,
  lppd_out_if.source                           out_ch,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [lppd_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int FW = $clog2(BUFFER_BYTES + 1);
  localparam int CMD_W = 2 + AW + 8 + FW + 8;

  logic [lppd_pkg::MAX_LEN_W-1:0] max_len;
  logic                           sel_max_len;

  logic             push;
  logic [CMD_W-1:0] push_cmd;
  logic             q_full;
  logic             cmd_valid;
  logic [CMD_W-1:0] cmd_data;
  logic             cmd_pop;

  always_comb begin
    pready = 1'b1;
    sel_max_len = paddr[lppd_pkg::APB_ADDR_W-1] == lppd_pkg::APB_INDEX_MAX_LEN;
    prdata = sel_max_len ? 32'(max_len) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= lppd_pkg::MAX_LEN_RESET;
    end else if (psel && penable && pwrite && pready && sel_max_len) begin
      max_len <= pwdata[lppd_pkg::MAX_LEN_W-1:0];
    end
  end

  lppd_front #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .max_len (max_len),
    .q_full  (q_full),
    .push    (push),
    .push_cmd(push_cmd)
  );

  lppd_queue #(
    .WIDTH(CMD_W),
    .DEPTH(lppd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_cmd),
    .full     (q_full),
    .pop      (cmd_pop),
    .pop_valid(cmd_valid),
    .pop_data (cmd_data)
  );

  lppd_back #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_data (cmd_data),
    .cmd_pop  (cmd_pop),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

>>> rtl/lppd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module lppd_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          status,
  input wire logic [7:0]                    out_byte,
  input wire logic [lppd_pkg::INDEX_W-1:0]  byte_index,
  input wire logic [7:0]                    frame_id,
  input wire logic                          last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(status) && $stable(out_byte) &&
      $stable(byte_index) && $stable(frame_id) && $stable(last))
    else $error("stalled result changed");

  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> last && out_byte == 8'd0 && byte_index == '0 &&
      frame_id == 8'd0)
    else $error("error result carries packet fields");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !status && !last |=>
      !out_valid || (!status && byte_index == $past(byte_index) + 1'b1))
    else $error("packet byte index did not advance by one");

endmodule

bind length_prefixed_packet_deframer lppd_checker u_lppd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .status    (out_ch.status),
  .out_byte  (out_ch.out_byte),
  .byte_index(out_ch.byte_index),
  .frame_id  (out_ch.frame_id),
  .last      (out_ch.last)
);

`default_nettype wire

>>> test/tb_length_prefixed_packet_deframer.sv
`timescale 1ns / 1ps

module tb_length_prefixed_packet_deframer;

  localparam int BUFFER_BYTES = lppd_pkg::BUFFER_BYTES_DEFAULT;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 300000;
  localparam logic [lppd_pkg::APB_ADDR_W-1:0] MAX_LEN_ADDR =
    {lppd_pkg::APB_INDEX_MAX_LEN, 2'b00};

  typedef struct packed {
    logic       action;
    logic [7:0] data;
  } stream_item_t;

  typedef struct packed {
    logic                         status;
    logic [7:0]                   out_byte;
    logic [lppd_pkg::INDEX_W-1:0] byte_index;
    logic [7:0]                   frame_id;
    logic                         last;
  } packet_byte_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [lppd_pkg::APB_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  lppd_in_if in_ch ();
  lppd_out_if out_ch ();

  length_prefixed_packet_deframer DUT (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  stream_item_t byte_feed[$];
  packet_byte_t expected_bytes[$];

  logic [7:0] rx_store[BUFFER_BYTES];
  int unsigned rx_fill;
  logic rx_closed;
  logic [lppd_pkg::MAX_LEN_W-1:0] cfg_max_len;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  logic in_taken;
  logic hold_go;
  logic receiver_held;
  int unsigned failures;
  int unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic note_failure(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    failures++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      note_failure($sformatf("%s mismatch: got %0h, expected %0h", name, got, want));
    end
  endtask

  task automatic deframe_item(logic action, logic [7:0] data);
    int unsigned pkt_len;
    int unsigned lim;
    packet_byte_t r;
    if (action == lppd_pkg::ACTION_RESTART) begin
      rx_fill = 0;
      rx_closed = 1'b0;
      return;
    end
    if (rx_closed) return;
    if (rx_fill < BUFFER_BYTES) begin
      rx_store[rx_fill] = data;
      rx_fill++;
    end
    if (rx_fill < lppd_pkg::HEADER_BYTES) return;
    pkt_len = 32'({rx_store[1], rx_store[0]});
    lim = (32'(cfg_max_len) < BUFFER_BYTES) ? 32'(cfg_max_len) : BUFFER_BYTES;
    if (pkt_len < lppd_pkg::HEADER_BYTES || pkt_len > lim) begin
      r.status = lppd_pkg::STATUS_ERROR;
      r.out_byte = '0;
      r.byte_index = '0;
      r.frame_id = '0;
      r.last = 1'b1;
      expected_bytes.push_back(r);
      rx_fill = 0;
      rx_closed = 1'b1;
      return;
    end
    if (rx_fill < pkt_len) return;
    for (int i = 0; i < pkt_len; i++) begin
      r.status = lppd_pkg::STATUS_BYTE;
      r.out_byte = rx_store[i];
      r.byte_index = lppd_pkg::INDEX_W'(i);
      r.frame_id = rx_store[2];
      r.last = (i == pkt_len - 1);
      expected_bytes.push_back(r);
    end
    rx_fill = 0;
  endtask

  task automatic queue_item(logic action, logic [7:0] data);
    stream_item_t it;
    it.action = action;
    it.data = data;
    byte_feed.push_back(it);
  endtask

  // Pushes the length field, a random id and random body bytes, count bytes in all.
  task automatic queue_packet(logic [15:0] len_field, int unsigned count);
    for (int i = 0; i < count; i++) begin
      if (i == 0) queue_item(lppd_pkg::ACTION_DATA, len_field[7:0]);
      else if (i == 1) queue_item(lppd_pkg::ACTION_DATA, len_field[15:8]);
      else queue_item(lppd_pkg::ACTION_DATA, 8'($urandom));
    end
  endtask

  task automatic queue_random_stream(int unsigned n_items);
    int unsigned queued;
    int unsigned kind;
    int unsigned len;
    int unsigned lim;
    int unsigned small_top;
    int unsigned cnt;
    logic [15:0] bad_len;
    queued = 0;
    lim = (32'(cfg_max_len) < BUFFER_BYTES) ? 32'(cfg_max_len) : BUFFER_BYTES;
    small_top = (lim < 12) ? lim : 12;
    while (queued < n_items) begin
      kind = $urandom_range(99);
      if (lim >= lppd_pkg::HEADER_BYTES && kind < 70) begin
        len = (kind < 4) ? lim : $urandom_range(small_top, lppd_pkg::HEADER_BYTES);
        queue_packet(16'(len), len);
        queued += len;
      end else if (lim >= lppd_pkg::HEADER_BYTES && kind < 85) begin
        len = $urandom_range(small_top, lppd_pkg::HEADER_BYTES);
        cnt = $urandom_range(len - 1, 1);
        queue_packet(16'(len), cnt);
        queue_item(lppd_pkg::ACTION_RESTART, 8'($urandom));
        queued += cnt + 1;
      end else if (kind < 96) begin
        case ($urandom_range(2))
          0: bad_len = 16'($urandom_range(lppd_pkg::HEADER_BYTES - 1));
          1: bad_len = 16'(lim + 1 + $urandom_range(3));
          default: bad_len = 16'($urandom_range(16'hFFFF, lim + 1));
        endcase
        cnt = lppd_pkg::HEADER_BYTES + $urandom_range(2);
        queue_packet(bad_len, cnt);
        queue_item(lppd_pkg::ACTION_RESTART, 8'($urandom));
        queued += cnt + 1;
      end else begin
        queue_item(lppd_pkg::ACTION_RESTART, 8'($urandom));
        queued++;
      end
    end
  endtask

  task automatic queue_directed_cases();
    queue_item(lppd_pkg::ACTION_DATA, 8'h03);
    queue_item(lppd_pkg::ACTION_DATA, 8'h00);
    queue_item(lppd_pkg::ACTION_DATA, 8'h00);
    queue_item(lppd_pkg::ACTION_DATA, 8'h04);
    queue_item(lppd_pkg::ACTION_DATA, 8'h00);
    queue_item(lppd_pkg::ACTION_DATA, 8'hFF);
    queue_item(lppd_pkg::ACTION_DATA, 8'hFF);
    // A length of two is only rejected once the id byte has arrived.
    queue_item(lppd_pkg::ACTION_DATA, 8'h02);
    queue_item(lppd_pkg::ACTION_DATA, 8'h00);
    queue_item(lppd_pkg::ACTION_DATA, 8'h5A);
    queue_item(lppd_pkg::ACTION_DATA, 8'h77);
    queue_item(lppd_pkg::ACTION_RESTART, 8'hFF);
    queue_item(lppd_pkg::ACTION_DATA, 8'h00);
    queue_item(lppd_pkg::ACTION_DATA, 8'h00);
    queue_item(lppd_pkg::ACTION_DATA, 8'h11);
    queue_item(lppd_pkg::ACTION_RESTART, 8'h00);
    queue_item(lppd_pkg::ACTION_DATA, 8'h05);
    queue_item(lppd_pkg::ACTION_DATA, 8'h00);
    queue_item(lppd_pkg::ACTION_DATA, 8'h22);
    queue_item(lppd_pkg::ACTION_DATA, 8'h33);
    queue_item(lppd_pkg::ACTION_RESTART, 8'h55);
    queue_item(lppd_pkg::ACTION_DATA, 8'hFF);
    queue_item(lppd_pkg::ACTION_DATA, 8'hFF);
    queue_item(lppd_pkg::ACTION_DATA, 8'h44);
    queue_item(lppd_pkg::ACTION_RESTART, 8'hAA);
  endtask

  task automatic wait_for_drain();
    logic busy;
    busy = 1'b1;
    while (busy) begin
      @(posedge clk);
      #1;
      busy = byte_feed.size() != 0 || in_ch.valid || expected_bytes.size() != 0;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic check_max_len();
    logic [31:0] rd;
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = MAX_LEN_ADDR;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    if (rd[lppd_pkg::MAX_LEN_W-1:0] !== cfg_max_len) begin
      note_failure($sformatf("max_packet_len read %0d, expected %0d",
                             rd[lppd_pkg::MAX_LEN_W-1:0], cfg_max_len));
    end
  endtask

  task automatic write_max_len(logic [lppd_pkg::MAX_LEN_W-1:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = MAX_LEN_ADDR;
    pwdata = 32'(value);
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    cfg_max_len = value;
    check_max_len();
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(negedge clk) begin
    stream_item_t it;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (byte_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        it = byte_feed.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.action <= it.action;
        in_ch.data_byte <= it.data;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= !receiver_held && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    in_taken <= !rst && in_ch.valid && in_ch.ready;
    if (!rst && in_ch.valid && in_ch.ready) begin
      deframe_item(in_ch.action, in_ch.data_byte);
    end
  end

  always @(posedge clk) begin
    packet_byte_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_bytes.size() == 0) begin
        note_failure($sformatf("unexpected transaction: status %0b byte %0h index %0d",
                               out_ch.status, out_ch.out_byte, out_ch.byte_index));
      end else begin
        want = expected_bytes.pop_front();
        check_field("status", 8'(out_ch.status), 8'(want.status));
        check_field("out_byte", out_ch.out_byte, want.out_byte);
        check_field("byte_index", 8'(out_ch.byte_index), 8'(want.byte_index));
        check_field("frame_id", out_ch.frame_id, want.frame_id);
        check_field("last", 8'(out_ch.last), 8'(want.last));
      end
    end
  end

  initial begin
    receiver_held = 1'b0;
    wait (hold_go);
    @(posedge clk);
    receiver_held = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    receiver_held = 1'b0;
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.action = lppd_pkg::ACTION_DATA;
    in_ch.data_byte = '0;
    out_ch.ready = 1'b0;
    in_taken = 1'b0;
    hold_go = 1'b0;
    failures = 0;
    cycle_count = 0;
    rx_fill = 0;
    rx_closed = 1'b0;
    cfg_max_len = lppd_pkg::MAX_LEN_RESET;
    send_idle_pct = 10;
    recv_idle_pct = 58;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    check_max_len();
    queue_directed_cases();
    queue_random_stream(16);
    wait_for_drain();

    write_max_len('0);
    queue_random_stream(6);
    wait_for_drain();

    write_max_len(7'(lppd_pkg::HEADER_BYTES));
    queue_random_stream(6);
    wait_for_drain();

    send_idle_pct = 58;
    recv_idle_pct = 10;
    write_max_len('1);
    queue_packet(16'(BUFFER_BYTES), BUFFER_BYTES);
    wait_for_drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_max_len(7'($urandom_range(BUFFER_BYTES, 20)));
    hold_go = 1'b1;
    for (int i = 0; i < 2; i++) begin
      queue_packet(16'd8, 8);
    end
    wait_for_drain();

    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
